// File: rtl/acdm_pkg.sv
// Shared types, constants and coefficient tables of the downmix matrix.
`default_nettype none
package acdm_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int ACC_W      = 32;
	localparam int MUL_A_W    = 26;
	localparam int COEF_W     = 18;
	localparam int PROD_W     = MUL_A_W + COEF_W;
	localparam int RND_W      = PROD_W - 16;
	localparam int NUM_LINES  = 7;
	localparam int LINE_W     = 3;
	localparam int MAX_CH     = 8;
	localparam int SLOT_W     = 3;
	localparam int NUM_OUTS   = 6;
	localparam int NUM_LABELS = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int DLY_W      = 10;
	localparam int ALPHA_W    = 17;

	localparam logic [CFG_IDX_W-1:0] REG_MIX_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MAP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HPH_ALPHA   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_FRONT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_SIDE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_REAR  = 3'd6;

	localparam logic [3:0] MODE_PASS = 4'd0;
	localparam logic [3:0] MODE_MONO = 4'd1;
	localparam logic [3:0] MODE_SHPH = 4'd10;

	localparam logic [LINE_W-1:0] LINE_NONE = 3'd7;
	localparam logic [1:0] DSEL_NONE  = 2'd0;
	localparam logic [1:0] DSEL_FRONT = 2'd1;
	localparam logic [1:0] DSEL_SIDE  = 2'd2;
	localparam logic [1:0] DSEL_REAR  = 2'd3;

	localparam logic [ALPHA_W-1:0] UNITY = 17'd65536;
	localparam logic [26:0] DIV3_RECIP = 27'd89478486;

	// Q.16 coefficients
	localparam logic signed [COEF_W-1:0] CK  = 18'sd46334;
	localparam logic signed [COEF_W-1:0] CB  = 18'sd38994;
	localparam logic signed [COEF_W-1:0] CC  = 18'sd30081;
	localparam logic signed [COEF_W-1:0] CH  = 18'sd32768;
	localparam logic signed [COEF_W-1:0] CU  = 18'sd65536;
	localparam logic signed [COEF_W-1:0] CS  = 18'sd56754;
	localparam logic signed [COEF_W-1:0] CT  = 18'sd6554;
	localparam logic signed [COEF_W-1:0] CZ  = 18'sd0;
	localparam logic signed [COEF_W-1:0] NCH = -18'sd32768;
	localparam logic signed [COEF_W-1:0] NCK = -18'sd46334;
	localparam logic signed [COEF_W-1:0] C_DECAY = 18'sd65529;
	localparam logic signed [COEF_W-1:0] C_BLEED = 18'sd3277;

	localparam logic signed [ACC_W-1:0] SAT_HI = 32'sd8388607;
	localparam logic signed [ACC_W-1:0] SAT_LO = -32'sd8388608;

	// Matrix modes 2..9: [mode-2][label][out]
	localparam logic signed [COEF_W-1:0] MTX_COEF [8][NUM_LABELS][NUM_OUTS] = '{
		'{ '{CK,CK,CZ,CZ,CZ,CZ}, '{CU,CZ,CZ,CZ,CZ,CZ}, '{CZ,CU,CZ,CZ,CZ,CZ},
		   '{CK,CK,CZ,CZ,CZ,CZ}, '{CU,CZ,CZ,CZ,CZ,CZ}, '{CZ,CU,CZ,CZ,CZ,CZ},
		   '{CK,CK,CZ,CZ,CZ,CZ}, '{CK,CK,CZ,CZ,CZ,CZ}, '{CU,CZ,CZ,CZ,CZ,CZ},
		   '{CZ,CU,CZ,CZ,CZ,CZ} },
		'{ '{CK,CK,CZ,CZ,CZ,CZ}, '{CU,CT,CZ,CZ,CZ,CZ}, '{CT,CU,CZ,CZ,CZ,CZ},
		   '{CK,CK,CZ,CZ,CZ,CZ}, '{CU,CT,CZ,CZ,CZ,CZ}, '{CT,CU,CZ,CZ,CZ,CZ},
		   '{CK,CK,CZ,CZ,CZ,CZ}, '{CK,CK,CZ,CZ,CZ,CZ}, '{CU,CT,CZ,CZ,CZ,CZ},
		   '{CT,CU,CZ,CZ,CZ,CZ} },
		'{ '{CK,CK,CZ,CZ,CZ,CZ}, '{CU,CZ,CZ,CZ,CZ,CZ}, '{CZ,CU,CZ,CZ,CZ,CZ},
		   '{CK,CK,CZ,CZ,CZ,CZ}, '{CZ,CZ,CU,CZ,CZ,CZ}, '{CZ,CZ,CU,CZ,CZ,CZ},
		   '{CZ,CZ,CU,CZ,CZ,CZ}, '{CB,CB,CB,CZ,CZ,CZ}, '{CK,CZ,CK,CZ,CZ,CZ},
		   '{CZ,CK,CK,CZ,CZ,CZ} },
		'{ '{CZ,CZ,CU,CZ,CZ,CZ}, '{CU,CZ,CZ,CZ,CZ,CZ}, '{CZ,CU,CZ,CZ,CZ,CZ},
		   '{CZ,CZ,CU,CZ,CZ,CZ}, '{CU,CZ,CZ,CZ,CZ,CZ}, '{CZ,CU,CZ,CZ,CZ,CZ},
		   '{CZ,CZ,CU,CZ,CZ,CZ}, '{CB,CB,CB,CZ,CZ,CZ}, '{CU,CZ,CZ,CZ,CZ,CZ},
		   '{CZ,CU,CZ,CZ,CZ,CZ} },
		'{ '{CZ,CZ,CZ,CU,CZ,CZ}, '{CU,CZ,CZ,CZ,CZ,CZ}, '{CZ,CU,CZ,CZ,CZ,CZ},
		   '{CZ,CZ,CZ,CU,CZ,CZ}, '{CZ,CZ,CU,CZ,CZ,CZ}, '{CZ,CZ,CU,CZ,CZ,CZ},
		   '{CZ,CZ,CU,CZ,CZ,CZ}, '{CH,CH,CH,CH,CZ,CZ}, '{CK,CZ,CK,CZ,CZ,CZ},
		   '{CZ,CK,CK,CZ,CZ,CZ} },
		'{ '{CK,CK,CZ,CZ,CZ,CZ}, '{CU,CZ,CZ,CZ,CZ,CZ}, '{CZ,CU,CZ,CZ,CZ,CZ},
		   '{CK,CK,CZ,CZ,CZ,CZ}, '{CZ,CZ,CU,CZ,CZ,CZ}, '{CZ,CZ,CZ,CU,CZ,CZ},
		   '{CZ,CZ,CK,CK,CZ,CZ}, '{CH,CH,CH,CH,CZ,CZ}, '{CK,CZ,CK,CZ,CZ,CZ},
		   '{CZ,CK,CZ,CK,CZ,CZ} },
		'{ '{CZ,CZ,CZ,CZ,CU,CZ}, '{CU,CZ,CZ,CZ,CZ,CZ}, '{CZ,CU,CZ,CZ,CZ,CZ},
		   '{CZ,CZ,CZ,CZ,CU,CZ}, '{CZ,CZ,CU,CZ,CZ,CZ}, '{CZ,CZ,CZ,CU,CZ,CZ},
		   '{CZ,CZ,CK,CK,CZ,CZ}, '{CC,CC,CC,CC,CC,CZ}, '{CK,CZ,CK,CZ,CZ,CZ},
		   '{CZ,CK,CZ,CK,CZ,CZ} },
		'{ '{CZ,CZ,CZ,CZ,CU,CZ}, '{CU,CZ,CZ,CZ,CZ,CZ}, '{CZ,CU,CZ,CZ,CZ,CZ},
		   '{CZ,CZ,CZ,CZ,CU,CZ}, '{CZ,CZ,CU,CZ,CZ,CZ}, '{CZ,CZ,CZ,CU,CZ,CZ},
		   '{CZ,CZ,CK,CK,CZ,CZ}, '{CZ,CZ,CZ,CZ,CZ,CU}, '{CK,CZ,CK,CZ,CZ,CZ},
		   '{CZ,CK,CZ,CK,CZ,CZ} }
	};

	// Surround headphone rows per label
	localparam logic signed [COEF_W-1:0] SHP_D0 [NUM_LABELS] =
		'{CK, CS, CZ, CK, CK, CZ, CZ, CK, CS, CZ};
	localparam logic signed [COEF_W-1:0] SHP_D1 [NUM_LABELS] =
		'{CK, CZ, CS, CK, CZ, CK, CZ, CK, CZ, CS};
	localparam logic signed [COEF_W-1:0] SHP_T0 [NUM_LABELS] =
		'{CZ, CZ, CH, CZ, CZ, NCH, CK, CZ, CZ, CH};
	localparam logic signed [COEF_W-1:0] SHP_T1 [NUM_LABELS] =
		'{CZ, CH, CZ, CZ, NCH, CZ, NCK, CZ, CH, CZ};
	localparam logic [LINE_W-1:0] SHP_LINE [NUM_LABELS] =
		'{3'd7, 3'd1, 3'd2, 3'd7, 3'd5, 3'd6, 3'd0, 3'd7, 3'd3, 3'd4};
	localparam logic [1:0] SHP_DSEL [NUM_LABELS] =
		'{2'd0, 2'd1, 2'd1, 2'd0, 2'd3, 2'd3, 2'd0, 2'd0, 2'd2, 2'd2};

	typedef enum logic [3:0] {
		MUL_MTX  = 4'd0,
		MUL_OLD  = 4'd1,
		MUL_T    = 4'd2,
		MUL_AX   = 4'd3,
		MUL_X05  = 4'd4,
		MUL_XR0  = 4'd5,
		MUL_DSR2 = 4'd6,
		MUL_XR1  = 4'd7,
		MUL_DSR3 = 4'd8
	} mul_op_t;

	typedef enum logic [2:0] {
		WB_NONE = 3'd0,
		WB_ACC  = 3'd1,
		WB_ADDX = 3'd2,
		WB_T    = 3'd3,
		WB_U    = 3'd4,
		WB_LINE = 3'd5,
		WB_DS   = 3'd6,
		WB_TAP  = 3'd7
	} wb_op_t;

	typedef enum logic [1:0] {
		RD_NONE = 2'd0,
		RD_OLD  = 2'd1,
		RD_TAP  = 2'd2
	} rd_op_t;

	typedef struct packed {
		logic [3:0]            mix_mode;
		logic [3:0]            in_channels;
		logic [31:0]           channel_map;
		logic [ALPHA_W-1:0]    hph_alpha;
		logic [DLY_W-1:0]      delay_front;
		logic [DLY_W-1:0]      delay_side;
		logic [DLY_W-1:0]      delay_rear;
	} cfg_t;

	typedef struct packed {
		logic        load;
		logic        clr;
		mul_op_t     mul;
		logic [2:0]  k;
		wb_op_t      wb;
		logic [2:0]  wb_k;
		rd_op_t      rd;
		logic        div1;
		logic        div2;
		logic        emit;
		logic        emit_last;
		logic        pass;
		logic        finish;
	} cmd_t;

	typedef struct packed {
		logic [3:0] mode;
		logic       label_ok;
		logic       line_none;
		logic       last;
		logic       out_free;
		logic       clr_done;
	} stat_t;

	function automatic logic [2:0] n_outs(input logic [3:0] mode);
		logic [2:0] r;
		unique case (mode)
			4'd2, 4'd3, 4'd10: r = 3'd2;
			4'd4, 4'd5:        r = 3'd3;
			4'd6, 4'd7:        r = 3'd4;
			4'd8:              r = 3'd5;
			4'd9:              r = 3'd6;
			default:           r = 3'd1;
		endcase
		return r;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat_s(input logic signed [ACC_W-1:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > SAT_HI)
			r = SAT_HI[SAMPLE_W-1:0];
		else if (v < SAT_LO)
			r = SAT_LO[SAMPLE_W-1:0];
		else
			r = v[SAMPLE_W-1:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/acdm_ctrl.sv
// Sequencer of the downmix matrix: steps the datapath through each sample.
`default_nettype none
module acdm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  acdm_pkg::stat_t   stat,
	output acdm_pkg::cmd_t    cmd
);
	import acdm_pkg::*;

	typedef enum logic [24:0] {
		S_CLR     = 25'h0000001,
		S_IDLE    = 25'h0000002,
		S_DISP    = 25'h0000004,
		S_PASS    = 25'h0000008,
		S_MONO    = 25'h0000010,
		S_MTX     = 25'h0000020,
		S_MTX_END = 25'h0000040,
		S_HRD     = 25'h0000080,
		S_HM1     = 25'h0000100,
		S_HM2     = 25'h0000200,
		S_HM3     = 25'h0000400,
		S_HM4     = 25'h0000800,
		S_HM5     = 25'h0001000,
		S_HRD2    = 25'h0002000,
		S_HTAP    = 25'h0004000,
		S_HD0     = 25'h0008000,
		S_HD1     = 25'h0010000,
		S_HD2     = 25'h0020000,
		S_HD3     = 25'h0040000,
		S_HD4     = 25'h0080000,
		S_END     = 25'h0100000,
		S_DIV1    = 25'h0200000,
		S_DIV2    = 25'h0400000,
		S_EMIT    = 25'h0800000,
		S_FIN     = 25'h1000000
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] k_q, k_d;
	logic [2:0] n_last;

	assign n_last   = n_outs(stat.mode) - 3'd1;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		cmd     = '0;
		unique case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (stat.clr_done)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				k_d = 3'd0;
				if (stat.mode == MODE_PASS)
					state_d = S_PASS;
				else if (stat.mode == MODE_MONO)
					state_d = S_MONO;
				else if (!stat.label_ok)
					state_d = S_END;
				else if (stat.mode != MODE_SHPH)
					state_d = S_MTX;
				else if (stat.line_none)
					state_d = S_HD0;
				else
					state_d = S_HRD;
			end
			S_PASS: begin
				if (stat.out_free) begin
					cmd.pass = 1'b1;
					state_d  = S_FIN;
				end
			end
			S_MONO: begin
				cmd.wb  = WB_ADDX;
				state_d = S_END;
			end
			S_MTX: begin
				cmd.mul  = MUL_MTX;
				cmd.k    = k_q;
				cmd.wb_k = k_q - 3'd1;
				cmd.wb   = (k_q != 3'd0) ? WB_ACC : WB_NONE;
				if (k_q == 3'(NUM_OUTS - 1)) begin
					k_d     = 3'd0;
					state_d = S_MTX_END;
				end else begin
					k_d = k_q + 3'd1;
				end
			end
			S_MTX_END: begin
				cmd.wb   = WB_ACC;
				cmd.wb_k = 3'(NUM_OUTS - 1);
				state_d  = S_END;
			end
			S_HRD: begin
				cmd.rd  = RD_OLD;
				state_d = S_HM1;
			end
			S_HM1: begin
				cmd.mul = MUL_OLD;
				state_d = S_HM2;
			end
			S_HM2: begin
				cmd.wb  = WB_T;
				state_d = S_HM3;
			end
			S_HM3: begin
				cmd.mul = MUL_T;
				state_d = S_HM4;
			end
			S_HM4: begin
				cmd.wb  = WB_U;
				cmd.mul = MUL_AX;
				state_d = S_HM5;
			end
			S_HM5: begin
				cmd.wb  = WB_LINE;
				cmd.mul = MUL_X05;
				state_d = S_HRD2;
			end
			S_HRD2: begin
				cmd.wb  = WB_DS;
				cmd.rd  = RD_TAP;
				state_d = S_HTAP;
			end
			S_HTAP: begin
				cmd.wb  = WB_TAP;
				state_d = S_HD0;
			end
			S_HD0: begin
				cmd.mul = MUL_XR0;
				state_d = S_HD1;
			end
			S_HD1: begin
				cmd.wb   = WB_ACC;
				cmd.wb_k = 3'd0;
				cmd.mul  = MUL_DSR2;
				state_d  = S_HD2;
			end
			S_HD2: begin
				cmd.wb   = WB_ACC;
				cmd.wb_k = 3'd0;
				cmd.mul  = MUL_XR1;
				state_d  = S_HD3;
			end
			S_HD3: begin
				cmd.wb   = WB_ACC;
				cmd.wb_k = 3'd1;
				cmd.mul  = MUL_DSR3;
				state_d  = S_HD4;
			end
			S_HD4: begin
				cmd.wb   = WB_ACC;
				cmd.wb_k = 3'd1;
				state_d  = S_END;
			end
			S_END: begin
				k_d = 3'd0;
				if (!stat.last)
					state_d = S_FIN;
				else if (stat.mode == MODE_MONO)
					state_d = S_DIV1;
				else
					state_d = S_EMIT;
			end
			S_DIV1: begin
				cmd.div1 = 1'b1;
				state_d  = S_DIV2;
			end
			S_DIV2: begin
				cmd.div2 = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				cmd.k = k_q;
				if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = (k_q == n_last);
					if (k_q == n_last) begin
						k_d     = 3'd0;
						state_d = S_FIN;
					end else begin
						k_d = k_q + 3'd1;
					end
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			k_q     <= 3'd0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/acdm_dp.sv
// Datapath of the downmix matrix: multiplier, accumulators, delay memory, output register.
`default_nettype none
module acdm_dp #(
	parameter int DELAY_DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  acdm_pkg::cfg_t                         cfg,
	input  acdm_pkg::cmd_t                         cmd,
	input  logic signed [acdm_pkg::SAMPLE_W-1:0]   in_sample,
	input  logic                                   out_ready,
	output acdm_pkg::stat_t                        stat,
	output logic                                   out_valid,
	output logic signed [acdm_pkg::SAMPLE_W-1:0]   out_sample,
	output logic [2:0]                             out_channel,
	output logic                                   out_last
);
	import acdm_pkg::*;

	localparam int AW        = $clog2(DELAY_DEPTH);
	localparam int MEM_DEPTH = NUM_LINES * DELAY_DEPTH;
	localparam int MA_W      = $clog2(MEM_DEPTH);

	// Per-sample context
	logic signed [SAMPLE_W-1:0] x_q;
	logic [SLOT_W-1:0]          slot_q;
	logic [3:0]                 mode_q;
	logic [3:0]                 n_q;
	logic [3:0]                 label_q;
	logic                       last_q;

	logic [3:0] mode_in, n_in, label_in;
	logic       last_in;

	assign mode_in  = (cfg.mix_mode > MODE_SHPH) ? MODE_PASS : cfg.mix_mode;
	assign n_in     = (cfg.in_channels == 4'd0) ? 4'd1 :
	                  (cfg.in_channels > 4'(MAX_CH)) ? 4'(MAX_CH) : cfg.in_channels;
	assign label_in = cfg.channel_map[{slot_q, 2'b00} +: 4];
	assign last_in  = (({1'b0, slot_q} + 4'd1) >= n_in);

	logic                     label_ok;
	logic [LINE_W-1:0]        line;
	logic [1:0]               dsel;

	assign label_ok = (label_q < 4'(NUM_LABELS));
	assign line     = label_ok ? SHP_LINE[label_q] : LINE_NONE;
	assign dsel     = label_ok ? SHP_DSEL[label_q] : DSEL_NONE;

	// Headphone line parameters
	logic [ALPHA_W-1:0] a_eff, a_inv;
	logic [DLY_W-1:0]   dly;

	assign a_eff = (dsel == DSEL_FRONT) ? UNITY :
	               (cfg.hph_alpha > UNITY) ? UNITY : cfg.hph_alpha;
	assign a_inv = UNITY - a_eff;

	always_comb begin
		unique case (dsel)
			DSEL_FRONT: dly = cfg.delay_front;
			DSEL_SIDE:  dly = cfg.delay_side;
			DSEL_REAR:  dly = cfg.delay_rear;
			default:    dly = '0;
		endcase
	end

	logic [AW-1:0]    pos_q [NUM_LINES];
	logic [AW-1:0]    pos_cur, pos_next, tap_pos;
	logic [AW+9:0]    tap_full;

	assign pos_cur  = pos_q[line];
	assign pos_next = pos_cur + AW'(1);
	assign tap_full = {{DLY_W{1'b0}}, pos_cur} - {{AW{1'b0}}, dly};
	assign tap_pos  = tap_full[AW-1:0];

	// Shared multiplier with registered product
	logic signed [MUL_A_W-1:0] t_q, u_q, ds_q;
	logic signed [SAMPLE_W-1:0] rd_q;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [COEF_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [PROD_W-1:0]  rnd_sum;
	logic signed [RND_W-1:0]   rnd_w;
	logic signed [MUL_A_W-1:0] x_ext;
	logic [2:0]                mode_row;

	assign x_ext    = {{(MUL_A_W-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q};
	assign mode_row = 3'(mode_q - 4'd2);

	always_comb begin
		mul_a = x_ext;
		mul_b = CZ;
		unique case (cmd.mul)
			MUL_MTX: mul_b = MTX_COEF[mode_row][label_q][cmd.k];
			MUL_OLD: begin
				mul_a = {{(MUL_A_W-SAMPLE_W){rd_q[SAMPLE_W-1]}}, rd_q};
				mul_b = {1'b0, a_inv};
			end
			MUL_T: begin
				mul_a = t_q;
				mul_b = C_DECAY;
			end
			MUL_AX:   mul_b = {1'b0, a_eff};
			MUL_X05:  mul_b = C_BLEED;
			MUL_XR0:  mul_b = SHP_D0[label_q];
			MUL_DSR2: begin
				mul_a = ds_q;
				mul_b = SHP_T0[label_q];
			end
			MUL_XR1:  mul_b = SHP_D1[label_q];
			MUL_DSR3: begin
				mul_a = ds_q;
				mul_b = SHP_T1[label_q];
			end
			default: mul_b = CZ;
		endcase
	end

	assign rnd_sum = prod_s1 + 44'sd32768;
	assign rnd_w   = rnd_sum[PROD_W-1:16];

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	// Delay line value written back: rounded a*x plus the decayed old sample
	logic signed [ACC_W-1:0] line_sum;
	assign line_sum = {{(ACC_W-RND_W){rnd_w[RND_W-1]}}, rnd_w}
	                + {{(ACC_W-MUL_A_W){u_q[MUL_A_W-1]}}, u_q};

	always_ff @(posedge clk) begin
		unique case (cmd.wb)
			WB_T:  t_q  <= rnd_w[MUL_A_W-1:0];
			WB_U:  u_q  <= rnd_w[MUL_A_W-1:0];
			WB_DS: ds_q <= rnd_w[MUL_A_W-1:0];
			WB_TAP: ds_q <= ds_q + {{(MUL_A_W-SAMPLE_W){rd_q[SAMPLE_W-1]}}, rd_q};
			default: begin
				if (cmd.load)
					ds_q <= '0;
			end
		endcase
	end

	// Delay memory, cleared by a sweep after reset
	logic signed [SAMPLE_W-1:0] mem [0:MEM_DEPTH-1];
	logic [MA_W-1:0]            clr_addr_q;
	logic                       mem_we, mem_re;
	logic [MA_W-1:0]            waddr, raddr;
	logic signed [SAMPLE_W-1:0] wdata;

	assign mem_we = cmd.clr || (cmd.wb == WB_LINE);
	assign waddr  = cmd.clr ? clr_addr_q : MA_W'({line, pos_next});
	assign wdata  = cmd.clr ? '0 : sat_s(line_sum);
	assign mem_re = (cmd.rd != RD_NONE);
	assign raddr  = (cmd.rd == RD_TAP) ? MA_W'({line, tap_pos}) : MA_W'({line, pos_cur});

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= wdata;
		if (mem_re)
			rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr) begin
			clr_addr_q <= clr_addr_q + MA_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LINES; i++)
				pos_q[i] <= '0;
		end else if (cmd.wb == WB_LINE) begin
			pos_q[line] <= pos_next;
		end
	end

	// Context and accumulators
	logic signed [ACC_W-1:0] acc_q [NUM_OUTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			mode_q  <= MODE_PASS;
			n_q     <= 4'd1;
			label_q <= '0;
			last_q  <= 1'b0;
			for (int i = 0; i < NUM_OUTS; i++)
				acc_q[i] <= '0;
		end else begin
			if (cmd.load) begin
				mode_q  <= mode_in;
				n_q     <= n_in;
				label_q <= label_in;
				last_q  <= last_in;
			end
			if (cmd.wb == WB_ACC)
				acc_q[cmd.wb_k] <= acc_q[cmd.wb_k]
				                 + {{(ACC_W-RND_W){rnd_w[RND_W-1]}}, rnd_w};
			else if (cmd.wb == WB_ADDX)
				acc_q[0] <= acc_q[0] + {{(ACC_W-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q};
			if (cmd.finish) begin
				if (last_q) begin
					slot_q <= '0;
					for (int i = 0; i < NUM_OUTS; i++)
						acc_q[i] <= '0;
				end else begin
					slot_q <= slot_q + SLOT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			x_q <= in_sample;
	end

	// Mono: |sum| shifted by the power-of-two part of the divisor, then a
	// reciprocal multiply when the divisor is six.
	logic [ACC_W-1:0]  mag;
	logic [ACC_W-1:0]  mag_sh;
	logic [25:0]       m_sh_q;
	logic              neg_q, div3_q;
	logic [52:0]       p3;
	logic [25:0]       q_div;
	logic signed [RND_W-1:0] mono_q;

	assign mag = acc_q[0][ACC_W-1] ? ACC_W'(-acc_q[0]) : acc_q[0];

	always_comb begin
		unique case (n_q)
			4'd3, 4'd4: mag_sh = mag >> 2;
			4'd7, 4'd8: mag_sh = mag >> 3;
			default:    mag_sh = mag >> 1;
		endcase
	end

	assign p3    = 53'(m_sh_q) * 53'(DIV3_RECIP);
	assign q_div = div3_q ? {1'b0, p3[52:28]} : m_sh_q;

	always_ff @(posedge clk) begin
		if (cmd.div1) begin
			m_sh_q <= mag_sh[25:0];
			neg_q  <= acc_q[0][ACC_W-1];
			div3_q <= (n_q == 4'd5) || (n_q == 4'd6);
		end
		if (cmd.div2)
			mono_q <= neg_q ? -$signed({2'b00, q_div}) : $signed({2'b00, q_div});
	end

	// Output register
	logic signed [ACC_W-1:0] emit_val;
	assign emit_val = (mode_q == MODE_MONO) ? {{(ACC_W-RND_W){mono_q[RND_W-1]}}, mono_q}
	                                        : acc_q[cmd.k];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit || cmd.pass) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pass) begin
			out_sample  <= x_q;
			out_channel <= slot_q;
			out_last    <= last_q;
		end else if (cmd.emit) begin
			out_sample  <= sat_s(emit_val);
			out_channel <= cmd.k;
			out_last    <= cmd.emit_last;
		end
	end

	assign stat.mode      = mode_q;
	assign stat.label_ok  = label_ok;
	assign stat.line_none = (line == LINE_NONE);
	assign stat.last      = last_q;
	assign stat.out_free  = !out_valid || out_ready;
	assign stat.clr_done  = (clr_addr_q == MA_W'(MEM_DEPTH - 1));

endmodule
`default_nettype wire

// File: rtl/audio_channel_downmix_matrix_top.sv
// Top level of the channel downmix matrix: configuration registers and stream ports.
//
// Usage: interleaved channel samples (Q1.23) enter on the s_ stream, one slot per
// transaction. Each slot is labeled by a 4-bit speaker code from channel_map and
// is weighted into the output channels of the selected layout. When the last slot
// of a frame is taken, the frame's output channels leave on the m_ stream one per
// transaction, saturated to 24 bits, with m_tuser holding the output channel and
// m_tlast set on the last one. In passthrough each sample leaves as it came.
// In surround headphones one shared multiplier and the delay memory are walked
// through in turn. At the end of a frame each result leaves in turn, and mono
// first runs its divide. After reset the delay memory is swept to zero, with
// s_tready low. When the receiver stalls, the output register holds its
// transaction and the sequencer waits for it.
// Configuration is written through cfg_we, cfg_index and cfg_data while idle;
// the user must keep to this, as the block itself does not enforce it.
`default_nettype none
module audio_channel_downmix_matrix_top #(
	parameter int DELAY_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [23:0] in_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [23:0] out_sample
	output logic [2:0]  m_tuser,   // [2:0] out_channel
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [acdm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [acdm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import acdm_pkg::*;

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t stat;
	logic signed [SAMPLE_W-1:0] out_sample;

	// Configuration registers; writes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mix_mode    <= 4'd0;
			cfg_q.in_channels <= 4'd2;
			cfg_q.channel_map <= 32'd0;
			cfg_q.hph_alpha   <= 17'd5500;
			cfg_q.delay_front <= 10'd14;
			cfg_q.delay_side  <= 10'd28;
			cfg_q.delay_rear  <= 10'd19;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIX_MODE:    cfg_q.mix_mode    <= cfg_data[3:0];
				REG_IN_CHANNELS: cfg_q.in_channels <= cfg_data[3:0];
				REG_CHANNEL_MAP: cfg_q.channel_map <= cfg_data;
				REG_HPH_ALPHA:   cfg_q.hph_alpha   <= cfg_data[ALPHA_W-1:0];
				REG_DELAY_FRONT: cfg_q.delay_front <= cfg_data[DLY_W-1:0];
				REG_DELAY_SIDE:  cfg_q.delay_side  <= cfg_data[DLY_W-1:0];
				REG_DELAY_REAR:  cfg_q.delay_rear  <= cfg_data[DLY_W-1:0];
				default: ;
			endcase
		end
	end

	// The sequencer takes a new transaction only in its idle state.
	acdm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	acdm_dp #(
		.DELAY_DEPTH (DELAY_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.in_sample   (s_tdata),
		.out_ready   (m_tready),
		.stat        (stat),
		.out_valid   (m_tvalid),
		.out_sample  (out_sample),
		.out_channel (m_tuser),
		.out_last    (m_tlast)
	);

	assign m_tdata = out_sample;

endmodule
`default_nettype wire

// File: sim/downmix_checker.sv
// Checker for the downmix matrix: tracks configuration, predicts output frames and compares them.
`timescale 1ns / 1ps
module downmix_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic [2:0]  m_tuser,
	input  logic        m_tlast,
	input  logic        cfg_we,
	input  logic [acdm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [acdm_pkg::CFG_DATA_W-1:0] cfg_data,
	output int          errors,
	output int          pending
);
	import acdm_pkg::*;

	localparam int DEPTH = 1024;
	localparam int K = 46334, B = 38994, C = 30081, H = 32768, U = 65536, S = 56754, T = 6554;
	localparam int NOLINE = 7;

	typedef struct {
		logic signed [23:0] sample;
		logic [2:0]         chan;
		logic               last;
	} mixed_t;

	// Weights of the matrix layouts 2..9, by [layout-2][speaker][output].
	localparam int WEIGHT [8][10][6] = '{
		'{'{K,K,0,0,0,0},'{U,0,0,0,0,0},'{0,U,0,0,0,0},'{K,K,0,0,0,0},'{U,0,0,0,0,0},
		  '{0,U,0,0,0,0},'{K,K,0,0,0,0},'{K,K,0,0,0,0},'{U,0,0,0,0,0},'{0,U,0,0,0,0}},
		'{'{K,K,0,0,0,0},'{U,T,0,0,0,0},'{T,U,0,0,0,0},'{K,K,0,0,0,0},'{U,T,0,0,0,0},
		  '{T,U,0,0,0,0},'{K,K,0,0,0,0},'{K,K,0,0,0,0},'{U,T,0,0,0,0},'{T,U,0,0,0,0}},
		'{'{K,K,0,0,0,0},'{U,0,0,0,0,0},'{0,U,0,0,0,0},'{K,K,0,0,0,0},'{0,0,U,0,0,0},
		  '{0,0,U,0,0,0},'{0,0,U,0,0,0},'{B,B,B,0,0,0},'{K,0,K,0,0,0},'{0,K,K,0,0,0}},
		'{'{0,0,U,0,0,0},'{U,0,0,0,0,0},'{0,U,0,0,0,0},'{0,0,U,0,0,0},'{U,0,0,0,0,0},
		  '{0,U,0,0,0,0},'{0,0,U,0,0,0},'{B,B,B,0,0,0},'{U,0,0,0,0,0},'{0,U,0,0,0,0}},
		'{'{0,0,0,U,0,0},'{U,0,0,0,0,0},'{0,U,0,0,0,0},'{0,0,0,U,0,0},'{0,0,U,0,0,0},
		  '{0,0,U,0,0,0},'{0,0,U,0,0,0},'{H,H,H,H,0,0},'{K,0,K,0,0,0},'{0,K,K,0,0,0}},
		'{'{K,K,0,0,0,0},'{U,0,0,0,0,0},'{0,U,0,0,0,0},'{K,K,0,0,0,0},'{0,0,U,0,0,0},
		  '{0,0,0,U,0,0},'{0,0,K,K,0,0},'{H,H,H,H,0,0},'{K,0,K,0,0,0},'{0,K,0,K,0,0}},
		'{'{0,0,0,0,U,0},'{U,0,0,0,0,0},'{0,U,0,0,0,0},'{0,0,0,0,U,0},'{0,0,U,0,0,0},
		  '{0,0,0,U,0,0},'{0,0,K,K,0,0},'{C,C,C,C,C,0},'{K,0,K,0,0,0},'{0,K,0,K,0,0}},
		'{'{0,0,0,0,U,0},'{U,0,0,0,0,0},'{0,U,0,0,0,0},'{0,0,0,0,U,0},'{0,0,U,0,0,0},
		  '{0,0,0,U,0,0},'{0,0,K,K,0,0},'{0,0,0,0,0,U},'{K,0,K,0,0,0},'{0,K,0,K,0,0}}
	};

	// Surround headphones per speaker: direct left/right, tap left/right, line, delay select.
	localparam int HPH [10][6] = '{
		'{K,K,0,0,NOLINE,0}, '{S,0,0,H,1,1}, '{0,S,H,0,2,1}, '{K,K,0,0,NOLINE,0},
		'{K,0,0,-H,5,3}, '{0,K,-H,0,6,3}, '{0,0,K,-K,0,0}, '{K,K,0,0,NOLINE,0},
		'{S,0,0,H,3,2}, '{0,S,H,0,4,2}
	};
	localparam int OUTS [11] = '{1, 1, 2, 2, 3, 3, 4, 4, 5, 6, 2};

	logic [3:0]  mode_r, chans_r;
	logic [31:0] map_r;
	logic [16:0] alpha_r;
	logic [9:0]  dfront_r, dside_r, drear_r;
	longint      acc [6];
	int          slot;
	int          line_mem [7][DEPTH];
	int          line_pos [7];
	mixed_t      frame_q [$];

	function automatic longint round_q16(input longint v);
		return (v + 32768) >>> 16;
	endfunction

	function automatic longint clamp24(input longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return v;
	endfunction

	// One step of a headphone line: lowpass write one past the head, then read the delayed tap.
	function automatic longint line_step(input int ln, input longint x, input longint a,
	                                     input int d);
		int p, pn, pp;
		longint v;
		p  = line_pos[ln];
		pn = (p + 1) % DEPTH;
		pp = (pn - d + DEPTH) % DEPTH;
		v  = round_q16(a * x) + round_q16(round_q16((65536 - a) * line_mem[ln][p]) * 65529);
		line_mem[ln][pn] = int'(clamp24(v));
		line_pos[ln] = pn;
		return line_mem[ln][pp];
	endfunction

	task automatic mix_sample(input logic [23:0] raw);
		longint x, ds, a, v;
		int n, md, lbl, no, d;
		bit last;
		mixed_t r;
		x  = longint'(signed'(raw));
		n  = chans_r;
		if (n < 1) n = 1;
		if (n > 8) n = 8;
		md = (mode_r > MODE_SHPH) ? int'(MODE_PASS) : int'(mode_r);
		last = (slot + 1 >= n);
		lbl = map_r[4*slot +: 4];
		if (md == MODE_PASS) begin
			r.sample = raw;
			r.chan = slot[2:0];
			r.last = last;
			frame_q.push_back(r);
		end else if (md == MODE_MONO) begin
			acc[0] += x;
		end else if (lbl < 10) begin
			if (md == MODE_SHPH) begin
				ds = 0;
				if (HPH[lbl][4] != NOLINE) begin
					a = (alpha_r > 65536) ? 65536 : alpha_r;
					d = 0;
					case (HPH[lbl][5])
						1: begin
							a = 65536;
							d = dfront_r;
						end
						2: d = dside_r;
						3: d = drear_r;
						default: d = 0;
					endcase
					ds = line_step(HPH[lbl][4], x, a, d) + round_q16(x * 3277);
				end
				acc[0] += round_q16(x * HPH[lbl][0]) + round_q16(ds * HPH[lbl][2]);
				acc[1] += round_q16(x * HPH[lbl][1]) + round_q16(ds * HPH[lbl][3]);
			end else begin
				for (int k = 0; k < OUTS[md]; k++)
					acc[k] += round_q16(x * WEIGHT[md-2][lbl][k]);
			end
		end
		if (last) begin
			if (md != MODE_PASS) begin
				no = OUTS[md];
				for (int k = 0; k < no; k++) begin
					v = acc[k];
					// Signed divide by the even count, truncated toward zero.
					if (md == MODE_MONO) v = v / longint'((n + 1) & ~1);
					r.sample = 24'(clamp24(v));
					r.chan = k[2:0];
					r.last = (k == no - 1);
					frame_q.push_back(r);
				end
			end
			foreach (acc[k]) acc[k] = 0;
			slot = 0;
		end else begin
			slot = slot + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_r   = MODE_PASS;
			chans_r  = 4'd2;
			map_r    = '0;
			alpha_r  = 17'd5500;
			dfront_r = 10'd14;
			dside_r  = 10'd28;
			drear_r  = 10'd19;
			foreach (acc[k]) acc[k] = 0;
			slot = 0;
			foreach (line_mem[i, j]) line_mem[i][j] = 0;
			foreach (line_pos[i]) line_pos[i] = 0;
			frame_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MIX_MODE:    mode_r   = cfg_data[3:0];
					REG_IN_CHANNELS: chans_r  = cfg_data[3:0];
					REG_CHANNEL_MAP: map_r    = cfg_data;
					REG_HPH_ALPHA:   alpha_r  = cfg_data[16:0];
					REG_DELAY_FRONT: dfront_r = cfg_data[9:0];
					REG_DELAY_SIDE:  dside_r  = cfg_data[9:0];
					REG_DELAY_REAR:  drear_r  = cfg_data[9:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				mix_sample(s_tdata);
			if (m_tvalid && m_tready) begin
				if (frame_q.size() == 0) begin
					$error("unexpected output transaction: out_sample %0d", $signed(m_tdata));
					errors++;
				end else begin
					mixed_t e;
					e = frame_q.pop_front();
					if (m_tdata !== e.sample) begin
						$error("out_sample: expected %0d, got %0d", e.sample, $signed(m_tdata));
						errors++;
					end
					if (m_tuser !== e.chan) begin
						$error("out_channel: expected %0d, got %0d", e.chan, m_tuser);
						errors++;
					end
					if (m_tlast !== e.last) begin
						$error("frame_last: expected %0d, got %0d", e.last, m_tlast);
						errors++;
					end
				end
			end
			pending = frame_q.size();
		end
	end

endmodule

// File: sim/testbench.sv
// Top of the downmix matrix simulation: clock, reset, configuration phases and sample stimulus.
`timescale 1ns / 1ps
module testbench;
	import acdm_pkg::*;

	// Generous bound on the length of a correct run.
	localparam int CYCLE_LIMIT = 400000;
	// Cycles to let the block settle after the last expected transaction.
	localparam int SETTLE = 48;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int          errors;
	int          pending;
	int          cycles;
	bit          quiet;

	audio_channel_downmix_matrix_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	downmix_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// The receiver stalls in random bursts, except during the quiet tail of the run.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// Leaves cfg_we high; the caller lowers it after its last write so that back-to-back
	// writes never see a lower and a raise in the same time step.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic set_layout(input logic [3:0] mode, input logic [3:0] chans,
	                          input logic [31:0] map, input logic [16:0] alpha,
	                          input logic [9:0] dfront, input logic [9:0] dside,
	                          input logic [9:0] drear);
		write_reg(REG_MIX_MODE, 32'(mode));
		write_reg(REG_IN_CHANNELS, 32'(chans));
		write_reg(REG_CHANNEL_MAP, map);
		write_reg(REG_HPH_ALPHA, 32'(alpha));
		write_reg(REG_DELAY_FRONT, 32'(dfront));
		write_reg(REG_DELAY_SIDE, 32'(dside));
		write_reg(REG_DELAY_REAR, 32'(drear));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Sends one channel sample. The valid stays up across consecutive samples and only
	// drops for a random gap, so the sender's gaps land at every point of the block's work.
	task automatic send_sample(input logic [23:0] v);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stops sending and holds off until every expected transaction has come out, then lets
	// the block finish any frame work that produces nothing, so registers can be changed.
	task automatic drain;
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Random sample: half full-range, else small around zero or near the rails to drive saturation.
	function automatic logic [23:0] any_sample();
		case ($urandom_range(0, 5))
			0: return 24'h7FFFFF - 24'($urandom_range(0, 15));
			1: return 24'h800000 + 24'($urandom_range(0, 15));
			2: return 24'($urandom_range(0, 255)) - 24'd128;
			default: return 24'($urandom);
		endcase
	endfunction

	initial begin
		logic [3:0]  mode, chans;
		logic [31:0] map;
		logic [16:0] alpha;
		logic [9:0]  df, dsd, dr;
		int          nitems;

		cycles    = 0;
		quiet     = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		// The delay memory is swept clean after reset; the block reports ready when done.
		do @(posedge clk); while (!s_tready);

		// Directed: passthrough with the rails, zero, minus one and alternating bit patterns.
		set_layout(MODE_PASS, 4'd3, 32'h0, 17'd5500, 10'd14, 10'd28, 10'd19);
		send_sample(24'h7FFFFF);
		send_sample(24'h800000);
		send_sample(24'h000000);
		send_sample(24'hFFFFFF);
		send_sample(24'h555555);
		send_sample(24'hAAAAAA);
		drain();
		// An undefined layout code behaves as passthrough; a zero channel count acts as one.
		set_layout(4'd15, 4'd0, 32'hFFFFFFFF, 17'd0, 10'd0, 10'd0, 10'd0);
		send_sample(24'h123456);
		send_sample(24'hEDCBA9);
		drain();
		// Mono over five slots: the sum is divided by six, truncated toward zero.
		set_layout(MODE_MONO, 4'd5, 32'h0, 17'd5500, 10'd14, 10'd28, 10'd19);
		repeat (5) send_sample(24'h7FFFFF);
		drain();
		// Full 3F2R+LFE frame at the positive rail saturates several outputs; a count
		// above the maximum acts as eight.
		set_layout(4'd9, 4'd15, 32'h76543210, 17'd5500, 10'd14, 10'd28, 10'd19);
		repeat (8) send_sample(24'h7FFFFF);
		drain();
		// Surround headphones with lines 0, 3, 4, 5 and 6 in use, an oversized alpha and extreme delays;
		// the slots labeled above nine contribute nothing.
		set_layout(MODE_SHPH, 4'd8, 32'hFA987654, 17'h1FFFF, 10'd1023, 10'd0, 10'd1);
		repeat (8) send_sample(24'h800000);
		drain();

		// Random phases. The first eleven walk every layout in order, the rest pick freely.
		// Short delays are favored so that headphone taps read back recently written values.
		for (int ph = 0; ph < 16; ph++) begin
			mode  = (ph < 11) ? 4'(ph) : 4'($urandom_range(0, 15));
			chans = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
			                                    : 4'($urandom_range(1, 8));
			map   = $urandom;
			if ($urandom_range(0, 1) == 0)
				for (int s = 0; s < 8; s++) map[4*s +: 4] = 4'($urandom_range(0, 9));
			case ($urandom_range(0, 3))
				0: alpha = 17'd0;
				1: alpha = 17'd65536;
				2: alpha = 17'($urandom_range(65537, 131071));
				default: alpha = 17'($urandom_range(0, 65536));
			endcase
			df  = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 6));
			dsd = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 6));
			dr  = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 6));
			if (ph >= 13) quiet = 1'b1;
			set_layout(mode, chans, map, alpha, df, dsd, dr);
			nitems = $urandom_range(9, 14);
			for (int i = 0; i < nitems; i++)
				send_sample(any_sample());
			// A phase may stop mid-frame, so the next layout picks up a running frame.
			drain();
		end

		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

// File: audio_channel_downmix_matrix_top.f
rtl/acdm_pkg.sv
rtl/acdm_ctrl.sv
rtl/acdm_dp.sv
rtl/audio_channel_downmix_matrix_top.sv
sim/downmix_checker.sv
sim/testbench.sv
